### design/ps2_host_command_engine_defines.svh
// assertion helpers for the ps2 host command engine
`ifndef PS2_HOST_COMMAND_ENGINE_DEFINES_SVH
`define PS2_HOST_COMMAND_ENGINE_DEFINES_SVH

// same-cycle implication
`define PS2HCE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ps2 host command engine check failed");

// next-cycle implication
`define PS2HCE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ps2 host command engine check failed");

`endif

### design/ps2hce_pkg.sv
`default_nettype none
package ps2hce_pkg;

   localparam int CMD_DEPTH_DEFAULT  = 4;
   localparam int RESP_DEPTH_DEFAULT = 4;

   localparam logic [1:0] OP_START     = 2'd0;
   localparam logic [1:0] OP_BUS_EVENT = 2'd1;
   localparam logic [1:0] OP_RX_BYTE   = 2'd2;

   localparam logic [2:0] EV_GOING_IDLE  = 3'd0;
   localparam logic [2:0] EV_IDLING      = 3'd1;
   localparam logic [2:0] EV_FRAME_ACKED = 3'd2;
   localparam logic [2:0] EV_START_ERR   = 3'd3;
   localparam logic [2:0] EV_PARITY_ERR  = 3'd4;
   localparam logic [2:0] EV_STOP_ERR    = 3'd5;
   localparam logic [2:0] EV_TIMEOUT     = 3'd6;
   localparam logic [2:0] EV_NACK        = 3'd7;

   localparam logic [1:0] DONE_NONE    = 2'd0;
   localparam logic [1:0] DONE_OK      = 2'd1;
   localparam logic [1:0] DONE_FAIL    = 2'd2;
   localparam logic [1:0] DONE_TIMEOUT = 2'd3;

   localparam logic [7:0] DEV_ACK    = 8'hFA;
   localparam logic [7:0] DEV_RESEND = 8'hFE;
   localparam logic [3:0] TALLY_MAX  = 4'hF;
   localparam logic [2:0] MAX_ARGS   = 3'd3;

   localparam logic CSR_ERROR_LIMIT = 1'b0;
   localparam logic CSR_IDLE_LIMIT  = 1'b1;

   localparam logic [3:0] ERROR_LIMIT_RESET = 4'd3;
   localparam logic [3:0] IDLE_LIMIT_RESET  = 4'd5;

   typedef enum logic [4:0] {
      PH_IDLE       = 5'b00001,
      PH_READY      = 5'b00010,
      PH_WAIT_FRAME = 5'b00100,
      PH_WAIT_ACK   = 5'b01000,
      PH_WAIT_RESP  = 5'b10000
   } phase_type;

   typedef struct packed {
      phase_type  phase;
      logic [2:0] cmd_length;
      logic [2:0] cmd_position;
      logic [2:0] resp_length;
      logic [2:0] resp_position;
      logic [3:0] error_tally;
      logic [3:0] idle_tally;
   } ctl_type;

   typedef struct packed {
      logic [1:0] op;
      logic [2:0] bus_event;
      logic [7:0] rx_byte;
      logic [7:0] cmd_byte;
      logic [7:0] arg_first;
      logic [7:0] arg_second;
      logic [7:0] arg_third;
      logic [2:0] arg_count;
      logic [2:0] resp_expected;
      logic       bus_accepts;
   } req_type;

   typedef struct packed {
      logic        start_accepted;
      logic        send_valid;
      logic [7:0]  send_byte;
      logic [1:0]  done_status;
      logic [2:0]  resp_count;
      logic [31:0] resp_bytes;
      logic        pass_valid;
      logic [7:0]  pass_byte;
      logic        idle_notify;
   } rsp_type;

endpackage
`default_nettype wire

### design/ps2hce_step.sv
`default_nettype none
module ps2hce_step import ps2hce_pkg::*; #(
   parameter int CMD_DEPTH  = CMD_DEPTH_DEFAULT,
   parameter int RESP_DEPTH = RESP_DEPTH_DEFAULT
) (
   input  var ctl_type    ctl_cur,
   input  var logic [7:0] cmd_cur [CMD_DEPTH],
   input  var logic [7:0] resp_cur [RESP_DEPTH],
   input  var logic [3:0] error_limit,
   input  var logic [3:0] idle_limit,
   input  var req_type    req,
   output ctl_type        ctl_nxt,
   output logic [7:0]     cmd_nxt [CMD_DEPTH],
   output logic [7:0]     resp_nxt [RESP_DEPTH],
   output rsp_type        rsp
);

   localparam int CMD_AW  = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
   localparam int RESP_AW = (RESP_DEPTH > 1) ? $clog2(RESP_DEPTH) : 1;
   localparam logic [3:0] CMD_DEPTH_W  = 4'(CMD_DEPTH);
   localparam logic [3:0] RESP_DEPTH_W = 4'(RESP_DEPTH);
   localparam int PACK_N = (RESP_DEPTH < 4) ? RESP_DEPTH : 4;

   ctl_type    ctl;
   logic [7:0] cmd [CMD_DEPTH];
   logic [7:0] resp [RESP_DEPTH];
   logic       start_ok;
   logic       check;
   logic       ready_on_pass;
   logic       send;
   logic       fin;
   logic [1:0] status;

   assign start_ok = (req.arg_count <= MAX_ARGS)
                  && (({1'b0, req.arg_count} + 4'd1) <= CMD_DEPTH_W)
                  && ({1'b0, req.resp_expected} <= RESP_DEPTH_W);

   always_comb begin
      ctl           = ctl_cur;
      cmd           = cmd_cur;
      resp          = resp_cur;
      rsp           = '0;
      check         = 1'b0;
      ready_on_pass = 1'b0;
      send          = 1'b0;
      fin           = 1'b0;
      status        = DONE_NONE;

      unique case (req.op)
         OP_START: begin
            if (ctl.phase == PH_IDLE && start_ok) begin
               cmd[0] = req.cmd_byte;
               for (int j = 1; j < CMD_DEPTH; j++) begin
                  if (j <= 3 && 3'(j) <= req.arg_count) begin
                     case (j)
                        1:       cmd[j] = req.arg_first;
                        2:       cmd[j] = req.arg_second;
                        default: cmd[j] = req.arg_third;
                     endcase
                  end
               end
               ctl.cmd_position  = '0;
               ctl.resp_position = '0;
               ctl.error_tally   = '0;
               ctl.idle_tally    = '0;
               ctl.cmd_length    = req.arg_count + 3'd1;
               ctl.resp_length   = req.resp_expected;
               ctl.phase         = PH_READY;
               rsp.start_accepted = 1'b1;
               send = 1'b1;
            end
         end
         OP_BUS_EVENT: begin
            unique case (req.bus_event) inside
               EV_GOING_IDLE: send = 1'b1;
               EV_IDLING: begin
                  if (ctl.phase == PH_IDLE) begin
                     rsp.idle_notify = 1'b1;
                  end else begin
                     if (ctl.idle_tally != TALLY_MAX) ctl.idle_tally = ctl.idle_tally + 4'd1;
                     check = 1'b1;
                     send  = 1'b1;
                  end
               end
               EV_FRAME_ACKED: begin
                  if (ctl.phase == PH_WAIT_FRAME) ctl.phase = PH_WAIT_ACK;
               end
               EV_START_ERR, EV_PARITY_ERR, EV_STOP_ERR: begin
                  if (ctl.error_tally != TALLY_MAX) ctl.error_tally = ctl.error_tally + 4'd1;
                  check = 1'b1;
               end
               EV_TIMEOUT: begin
                  ctl.idle_tally = TALLY_MAX;
                  check = 1'b1;
               end
               default: begin
                  if (ctl.error_tally != TALLY_MAX) ctl.error_tally = ctl.error_tally + 4'd1;
                  check         = 1'b1;
                  ready_on_pass = 1'b1;
               end
            endcase
         end
         OP_RX_BYTE: begin
            unique case (ctl.phase)
               PH_WAIT_ACK: begin
                  if (req.rx_byte == DEV_ACK) begin
                     ctl.cmd_position = ctl.cmd_position + 3'd1;
                     if (ctl.cmd_position < ctl.cmd_length) begin
                        ctl.phase = PH_READY;
                     end else if (ctl.resp_length != 3'd0) begin
                        ctl.phase = PH_WAIT_RESP;
                     end else begin
                        fin    = 1'b1;
                        status = DONE_OK;
                     end
                  end else if (req.rx_byte == DEV_RESEND) begin
                     if (ctl.error_tally != TALLY_MAX) ctl.error_tally = ctl.error_tally + 4'd1;
                     check         = 1'b1;
                     ready_on_pass = 1'b1;
                  end else begin
                     ctl.error_tally = TALLY_MAX;
                     check = 1'b1;
                  end
               end
               PH_WAIT_RESP: begin
                  if ({1'b0, ctl.resp_position} < RESP_DEPTH_W) begin
                     resp[ctl.resp_position[RESP_AW-1:0]] = req.rx_byte;
                     ctl.resp_position = ctl.resp_position + 3'd1;
                  end
                  if (ctl.resp_position >= ctl.resp_length
                      || {1'b0, ctl.resp_position} >= RESP_DEPTH_W) begin
                     fin    = 1'b1;
                     status = DONE_OK;
                  end
               end
               PH_IDLE: begin
                  rsp.pass_valid = 1'b1;
                  rsp.pass_byte  = req.rx_byte;
               end
               default: ;
            endcase
         end
         default: ;
      endcase

      if (check && ctl.phase != PH_IDLE) begin
         if (ctl.error_tally >= error_limit) begin
            fin    = 1'b1;
            status = DONE_FAIL;
         end else if (ctl.idle_tally >= idle_limit) begin
            fin    = 1'b1;
            status = DONE_TIMEOUT;
         end else if (ready_on_pass) begin
            ctl.phase = PH_READY;
         end
      end

      if (fin) begin
         ctl.phase       = PH_IDLE;
         rsp.done_status = status;
         rsp.resp_count  = ctl.resp_position;
         for (int i = 0; i < PACK_N; i++) begin
            if (3'(i) < ctl.resp_position) rsp.resp_bytes[8*i +: 8] = resp[i];
         end
      end

      if (send && ctl.phase == PH_READY && ctl.cmd_position < ctl.cmd_length
          && {1'b0, ctl.cmd_position} < CMD_DEPTH_W && req.bus_accepts) begin
         rsp.send_valid = 1'b1;
         rsp.send_byte  = cmd[ctl.cmd_position[CMD_AW-1:0]];
         ctl.phase      = PH_WAIT_FRAME;
      end
   end

   assign ctl_nxt  = ctl;
   assign cmd_nxt  = cmd;
   assign resp_nxt = resp;

endmodule
`default_nettype wire

### design/ps2_host_command_engine.sv
// Host-side PS/2 command layer. Each req beat is a start item, a bus event or a byte received
// from the device; each accepted beat yields exactly one rsp beat, in the next cycle, carrying
// any byte to send, a completion status with the gathered response bytes, a passed-through
// byte or an idle flag. A beat can be accepted every cycle: the whole update is one
// combinational pass from the command state into the rsp output register, and req_ready is
// high while that register is empty or being drained. error_limit and idle_limit are written
// through the csr port; the user must do so while no command runs: the block does not check.
`default_nettype none
`include "ps2_host_command_engine_defines.svh"
module ps2_host_command_engine import ps2hce_pkg::*; #(
   parameter int CMD_DEPTH  = CMD_DEPTH_DEFAULT,
   parameter int RESP_DEPTH = RESP_DEPTH_DEFAULT
) (
   input  var logic    clock,
   input  var logic    reset,
   input  var logic    req_valid,
   output logic        req_ready,
   input  var req_type req_payload,
   output logic        rsp_valid,
   input  var logic    rsp_ready,
   output rsp_type     rsp_payload,
   input  var logic    csr_we,
   input  var logic    csr_index,
   input  var logic [3:0] csr_wdata
);

   ctl_type    ctl_ff;
   ctl_type    ctl_in;
   logic [7:0] cmd_ff [CMD_DEPTH];
   logic [7:0] cmd_in [CMD_DEPTH];
   logic [7:0] resp_ff [RESP_DEPTH];
   logic [7:0] resp_in [RESP_DEPTH];
   rsp_type    rsp_ff;
   rsp_type    rsp_in;
   logic       rsp_valid_ff;
   logic [3:0] error_limit_ff;
   logic [3:0] idle_limit_ff;
   logic       req_fire;
   logic       send_fire;
   logic       done_fire;
   logic       pass_fire;

   assign req_ready   = !rsp_valid_ff || rsp_ready;
   assign req_fire    = req_valid && req_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign send_fire = req_fire && rsp_in.send_valid;
   assign done_fire = req_fire && (rsp_in.done_status != DONE_NONE);
   assign pass_fire = req_fire && rsp_in.pass_valid;

   ps2hce_step #(
      .CMD_DEPTH  (CMD_DEPTH),
      .RESP_DEPTH (RESP_DEPTH)
   ) u_step (
      .ctl_cur     (ctl_ff),
      .cmd_cur     (cmd_ff),
      .resp_cur    (resp_ff),
      .error_limit (error_limit_ff),
      .idle_limit  (idle_limit_ff),
      .req         (req_payload),
      .ctl_nxt     (ctl_in),
      .cmd_nxt     (cmd_in),
      .resp_nxt    (resp_in),
      .rsp         (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff         <= '{phase: PH_IDLE, default: '0};
         rsp_valid_ff   <= 1'b0;
         error_limit_ff <= ERROR_LIMIT_RESET;
         idle_limit_ff  <= IDLE_LIMIT_RESET;
      end else begin
         if (req_fire) begin
            ctl_ff       <= ctl_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we && csr_index == CSR_ERROR_LIMIT) error_limit_ff <= csr_wdata;
         if (csr_we && csr_index == CSR_IDLE_LIMIT)  idle_limit_ff  <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff  <= cmd_in;
         resp_ff <= resp_in;
         rsp_ff  <= rsp_in;
      end
   end

   `PS2HCE_ASSERT_NEXT(a_beat_yields_rsp, clock, reset, req_fire, rsp_valid_ff)
   `PS2HCE_ASSERT_NEXT(a_send_waits_frame, clock, reset, send_fire, ctl_ff.phase == PH_WAIT_FRAME)
   `PS2HCE_ASSERT_NEXT(a_done_goes_idle, clock, reset, done_fire, ctl_ff.phase == PH_IDLE)
   `PS2HCE_ASSERT_NOW(a_pass_only_idle, clock, reset, pass_fire, ctl_ff.phase == PH_IDLE)

endmodule
`default_nettype wire

### dv/ps2_host_command_engine_test.sv
`timescale 1ns / 1ps
module ps2_host_command_engine_test import ps2hce_pkg::*;;

   localparam logic [1:0] OP_IDLE_SLOT = 2'd3;
   localparam int CYCLE_LIMIT = 200000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_payload;
   logic    csr_we;
   logic    csr_index;
   logic [3:0] csr_wdata;

   ps2_host_command_engine u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   // engine state as predicted
   phase_type  eng_phase;
   logic [7:0] cmd_bytes [4];
   logic [7:0] gathered [4];
   logic [2:0] cmd_len;
   logic [2:0] cmd_pos;
   logic [2:0] resp_len;
   logic [2:0] resp_pos;
   logic [3:0] err_tally;
   logic [3:0] idle_tally;
   logic [3:0] err_limit;
   logic [3:0] idle_limit;

   rsp_type due_results[$];
   int      beats_sent;
   int      burst_left;
   int      mismatches;
   int      cycle_count;
   int      stall_left;
   int      flow_left;
   bit      calm;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic void reset_engine_model();
      eng_phase = PH_IDLE;
      for (int i = 0; i < 4; i++) begin
         cmd_bytes[i] = '0;
         gathered[i] = '0;
      end
      cmd_len = '0;
      cmd_pos = '0;
      resp_len = '0;
      resp_pos = '0;
      err_tally = '0;
      idle_tally = '0;
      err_limit = ERROR_LIMIT_RESET;
      idle_limit = IDLE_LIMIT_RESET;
   endfunction

   function automatic void end_command(input logic [1:0] status, inout rsp_type r);
      r.done_status = status;
      r.resp_count = resp_pos;
      r.resp_bytes = '0;
      for (int i = 0; i < 4; i++)
         if (i < resp_pos) r.resp_bytes[8*i +: 8] = gathered[i];
      eng_phase = PH_IDLE;
   endfunction

   function automatic bit keep_going(inout rsp_type r);
      if (eng_phase == PH_IDLE) return 1'b0;
      if (err_tally >= err_limit) begin
         end_command(DONE_FAIL, r);
         return 1'b0;
      end
      if (idle_tally >= idle_limit) begin
         end_command(DONE_TIMEOUT, r);
         return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic void offer_byte(input logic accepts, inout rsp_type r);
      if (eng_phase == PH_READY && cmd_pos < cmd_len && accepts) begin
         r.send_valid = 1'b1;
         r.send_byte = cmd_bytes[cmd_pos[1:0]];
         eng_phase = PH_WAIT_FRAME;
      end
   endfunction

   function automatic void bump_errors();
      if (err_tally != TALLY_MAX) err_tally = err_tally + 4'd1;
   endfunction

   function automatic rsp_type advance_engine(input req_type b);
      rsp_type r;
      r = '0;
      case (b.op)
         OP_START: begin
            if (eng_phase == PH_IDLE && b.arg_count <= MAX_ARGS &&
                b.resp_expected <= RESP_DEPTH_DEFAULT) begin
               cmd_bytes[0] = b.cmd_byte;
               if (b.arg_count > 0) cmd_bytes[1] = b.arg_first;
               if (b.arg_count > 1) cmd_bytes[2] = b.arg_second;
               if (b.arg_count > 2) cmd_bytes[3] = b.arg_third;
               cmd_pos = '0;
               resp_pos = '0;
               err_tally = '0;
               idle_tally = '0;
               cmd_len = b.arg_count + 3'd1;
               resp_len = b.resp_expected;
               eng_phase = PH_READY;
               r.start_accepted = 1'b1;
               offer_byte(b.bus_accepts, r);
            end
         end
         OP_BUS_EVENT: begin
            case (b.bus_event)
               EV_GOING_IDLE: offer_byte(b.bus_accepts, r);
               EV_IDLING: begin
                  if (eng_phase == PH_IDLE) begin
                     r.idle_notify = 1'b1;
                  end else begin
                     if (idle_tally != TALLY_MAX) idle_tally = idle_tally + 4'd1;
                     void'(keep_going(r));
                     offer_byte(b.bus_accepts, r);
                  end
               end
               EV_FRAME_ACKED: begin
                  if (eng_phase == PH_WAIT_FRAME) eng_phase = PH_WAIT_ACK;
               end
               EV_START_ERR, EV_PARITY_ERR, EV_STOP_ERR: begin
                  bump_errors();
                  void'(keep_going(r));
               end
               EV_TIMEOUT: begin
                  idle_tally = TALLY_MAX;
                  void'(keep_going(r));
               end
               EV_NACK: begin
                  bump_errors();
                  if (keep_going(r)) eng_phase = PH_READY;
               end
               default: ;
            endcase
         end
         OP_RX_BYTE: begin
            if (eng_phase == PH_WAIT_ACK) begin
               if (b.rx_byte == DEV_ACK) begin
                  cmd_pos = cmd_pos + 3'd1;
                  if (cmd_pos < cmd_len) eng_phase = PH_READY;
                  else if (resp_len != 0) eng_phase = PH_WAIT_RESP;
                  else end_command(DONE_OK, r);
               end else if (b.rx_byte == DEV_RESEND) begin
                  bump_errors();
                  if (keep_going(r)) eng_phase = PH_READY;
               end else begin
                  err_tally = TALLY_MAX;
                  void'(keep_going(r));
               end
            end else if (eng_phase == PH_WAIT_RESP) begin
               if (resp_pos < RESP_DEPTH_DEFAULT) begin
                  gathered[resp_pos[1:0]] = b.rx_byte;
                  resp_pos = resp_pos + 3'd1;
               end
               if (resp_pos >= resp_len || resp_pos >= RESP_DEPTH_DEFAULT)
                  end_command(DONE_OK, r);
            end else if (eng_phase == PH_IDLE) begin
               r.pass_valid = 1'b1;
               r.pass_byte = b.rx_byte;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic req_type beat_of(input logic [1:0] op);
      logic [63:0] bits;
      req_type b;
      bits = {$urandom, $urandom};
      b = bits[$bits(req_type)-1:0];
      b.op = op;
      return b;
   endfunction

   task automatic send_beat(input req_type b);
      int gap;
      if (burst_left == 0) begin
         gap = calm ? 0 : $urandom_range(0, 5);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_payload <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      due_results.push_back(advance_engine(b));
      beats_sent++;
   endtask

   task automatic send_event(input logic [2:0] ev, input logic accepts);
      req_type b;
      b = beat_of(OP_BUS_EVENT);
      b.bus_event = ev;
      b.bus_accepts = accepts;
      send_beat(b);
   endtask

   task automatic send_rx(input logic [7:0] value);
      req_type b;
      b = beat_of(OP_RX_BYTE);
      b.rx_byte = value;
      send_beat(b);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (due_results.size() != 0) @(posedge clock);
   endtask

   task automatic set_limits(input logic [3:0] err_lim, input logic [3:0] idle_lim);
      drain();
      if (eng_phase != PH_IDLE) begin
         send_event(EV_TIMEOUT, 1'b0);
         drain();
      end
      csr_we <= 1'b1;
      csr_index <= CSR_ERROR_LIMIT;
      csr_wdata <= err_lim;
      @(posedge clock);
      err_limit = err_lim;
      csr_index <= CSR_IDLE_LIMIT;
      csr_wdata <= idle_lim;
      @(posedge clock);
      idle_limit = idle_lim;
      csr_we <= 1'b0;
   endtask

   // one command driven through its handshakes, with some stray beats mixed in
   task automatic run_command(input int noise_pct);
      req_type b;
      int steps;
      int pick;
      b = beat_of(OP_START);
      b.arg_count = 3'($urandom_range(0, 3));
      b.resp_expected = 3'($urandom_range(0, 4));
      send_beat(b);
      steps = 0;
      while (eng_phase != PH_IDLE && steps < 40) begin
         b = beat_of(2'($urandom_range(0, 3)));
         if ($urandom_range(0, 99) >= noise_pct) begin
            pick = $urandom_range(0, 15);
            case (eng_phase)
               PH_READY: begin
                  b.op = OP_BUS_EVENT;
                  b.bus_event = (pick < 4) ? EV_IDLING : EV_GOING_IDLE;
                  b.bus_accepts = ($urandom_range(0, 3) != 0);
               end
               PH_WAIT_FRAME: begin
                  b.op = OP_BUS_EVENT;
                  b.bus_event = (pick < 13) ? EV_FRAME_ACKED : 3'($urandom_range(3, 7));
               end
               PH_WAIT_ACK: begin
                  b.op = OP_RX_BYTE;
                  if (pick < 12) b.rx_byte = DEV_ACK;
                  else if (pick < 15) b.rx_byte = DEV_RESEND;
               end
               default: begin
                  b.op = OP_RX_BYTE;
                  if (pick == 0) begin
                     b.op = OP_BUS_EVENT;
                     b.bus_event = EV_NACK;
                  end
               end
            endcase
         end
         send_beat(b);
         steps++;
      end
      if (eng_phase != PH_IDLE) send_event(EV_TIMEOUT, 1'b0);
   endtask

   task automatic idle_noise(input int count);
      repeat (count) send_beat(beat_of(2'($urandom_range(1, 3))));
   endtask

   task automatic test_idle_traffic();
      req_type b;
      send_rx(8'h00);
      send_rx(8'hFF);
      send_event(EV_IDLING, 1'b1);
      send_event(EV_NACK, 1'b1);
      send_event(EV_TIMEOUT, 1'b0);
      b = beat_of(OP_IDLE_SLOT);
      send_beat(b);
   endtask

   task automatic test_rejected_starts();
      req_type b;
      b = beat_of(OP_START);
      b.arg_count = 3'd4;
      b.resp_expected = 3'd0;
      send_beat(b);
      b.arg_count = 3'd7;
      send_beat(b);
      b.arg_count = 3'd0;
      b.resp_expected = 3'd5;
      send_beat(b);
      b.resp_expected = 3'd7;
      send_beat(b);
   endtask

   task automatic test_full_command();
      req_type b;
      b = beat_of(OP_START);
      b.cmd_byte = 8'hFF;
      b.arg_first = 8'h00;
      b.arg_count = 3'd1;
      b.resp_expected = 3'd4;
      b.bus_accepts = 1'b1;
      send_beat(b);
      send_event(EV_FRAME_ACKED, 1'b0);
      send_rx(DEV_ACK);
      send_event(EV_GOING_IDLE, 1'b1);
      send_event(EV_FRAME_ACKED, 1'b0);
      send_rx(DEV_ACK);
      send_beat(beat_of(OP_START));
      send_rx(8'h00);
      send_rx(8'hFF);
      send_rx(8'h5A);
      send_rx(8'hA5);
   endtask

   task automatic test_resend_and_failure();
      req_type b;
      b = beat_of(OP_START);
      b.cmd_byte = 8'h00;
      b.arg_count = 3'd3;
      b.arg_first = 8'hFF;
      b.arg_second = 8'h00;
      b.arg_third = 8'hFF;
      b.resp_expected = 3'd0;
      b.bus_accepts = 1'b0;
      send_beat(b);
      send_event(EV_IDLING, 1'b1);
      send_event(EV_FRAME_ACKED, 1'b0);
      send_rx(DEV_RESEND);
      send_event(EV_GOING_IDLE, 1'b1);
      send_event(EV_FRAME_ACKED, 1'b0);
      send_rx(8'h00);
   endtask

   task automatic test_random_commands();
      logic [3:0] err_set [7] = '{4'd15, 4'd1, 4'd0, 4'd15, 4'd1, 4'd3, 4'd8};
      logic [3:0] idle_set [7] = '{4'd15, 4'd1, 4'd0, 4'd1, 4'd15, 4'd5, 4'd8};
      int quota;
      for (int s = 0; s < 9; s++) begin
         if (s < 7) set_limits(err_set[s], idle_set[s]);
         else set_limits(4'($urandom_range(1, 15)), 4'($urandom_range(1, 15)));
         calm = (s % 3 == 1);
         quota = beats_sent + ((s == 2) ? 40 : 110);
         while (beats_sent < quota) begin
            if ($urandom_range(0, 4) == 0) idle_noise($urandom_range(1, 4));
            else run_command(($urandom_range(0, 3) == 0) ? 25 : 5);
            if ($urandom_range(0, 9) == 0) drain();
         end
      end
      calm = 1'b0;
   endtask

   function automatic void check_field(input string field, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", field, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : check_results
      rsp_type want;
      rsp_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got = rsp_payload;
         if (due_results.size() == 0) begin
            $error("response beat with nothing expected");
            mismatches++;
         end else begin
            want = due_results.pop_front();
            check_field("start_accepted", want.start_accepted, got.start_accepted);
            check_field("send_valid", want.send_valid, got.send_valid);
            check_field("send_byte", want.send_byte, got.send_byte);
            check_field("done_status", want.done_status, got.done_status);
            check_field("resp_count", want.resp_count, got.resp_count);
            check_field("resp_bytes", want.resp_bytes, got.resp_bytes);
            check_field("pass_valid", want.pass_valid, got.pass_valid);
            check_field("pass_byte", want.pass_byte, got.pass_byte);
            check_field("idle_notify", want.idle_notify, got.idle_notify);
         end
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (flow_left > 0) begin
         flow_left--;
         rsp_ready <= 1'b1;
      end else begin
         stall_left = $urandom_range(0, 5);
         flow_left = $urandom_range(1, 10);
         rsp_ready <= (stall_left == 0);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_ready = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_ERROR_LIMIT;
      csr_wdata = '0;
      beats_sent = 0;
      burst_left = 0;
      mismatches = 0;
      cycle_count = 0;
      stall_left = 0;
      flow_left = 0;
      calm = 1'b0;
      reset_engine_model();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_idle_traffic();
      test_rejected_starts();
      test_full_command();
      test_resend_and_failure();
      test_random_commands();
      drain();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && due_results.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
